// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/fdbb_pkg.sv
// Package for the frame difference bounding box block: widths, register
// indices, result layout and size clamping. No dependencies.
package fdbb_pkg;

  localparam int NUM_LANES   = 4;
  localparam int CH_W        = 8;
  localparam int PIX_W       = NUM_LANES * CH_W;
  localparam int CFG_W       = 13;
  localparam int TOL_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int COORD_W     = 13;   // holds any column or row below an 8191 limit
  localparam int BOX_XY_W    = 12;
  localparam int BOX_WH_W    = 13;
  localparam int COUNT_W     = 25;
  localparam int IN_TDATA_W  = 2 * PIX_W;
  localparam int OUT_TDATA_W = 112;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_BEFORE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEFORE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AFTER_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AFTER_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd4;

  // Position tag travelling with a pixel pair
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
    logic               same;
  } pos_t;

  // Result layout on m_axis_tdata, last field in the lowest bits
  typedef struct packed {
    logic [1:0]          pad;
    logic [BOX_WH_W-1:0] box_height;
    logic [BOX_WH_W-1:0] box_width;
    logic [BOX_XY_W-1:0] box_y;
    logic [BOX_XY_W-1:0] box_x;
    logic [CH_W-1:0]     peak_delta;
    logic [COUNT_W-1:0]  frame_area;
    logic [COUNT_W-1:0]  diff_count;
    logic                comparable;
    logic                changed;
  } res_t;

  // Zero acts as one, anything above the limit acts as the limit
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W+1:0] maxv);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if ({2'b00, v} > maxv) begin
      r = maxv[CFG_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/fdbb_lane.sv
// One channel lane: absolute difference of two 8-bit samples and the
// tolerance compare. Depends on fdbb_pkg.
module fdbb_lane (
  input  logic [fdbb_pkg::CH_W-1:0]  a_i,
  input  logic [fdbb_pkg::CH_W-1:0]  b_i,
  input  logic [fdbb_pkg::TOL_W-1:0] tol_i,
  output logic [fdbb_pkg::CH_W-1:0]  delta_o,
  output logic                       hit_o
);
  import fdbb_pkg::*;

  assign delta_o = (a_i >= b_i) ? (a_i - b_i) : (b_i - a_i);
  assign hit_o   = delta_o > tol_i;

endmodule

// File: rtl/fdbb_merge.sv
// Merges the lane results: largest channel difference and any-hit flag.
// Depends on fdbb_pkg.
module fdbb_merge (
  input  logic [fdbb_pkg::NUM_LANES-1:0][fdbb_pkg::CH_W-1:0] delta_i,
  input  logic [fdbb_pkg::NUM_LANES-1:0]                     hit_i,
  output logic [fdbb_pkg::CH_W-1:0]                          max_o,
  output logic                                               hit_o
);
  import fdbb_pkg::*;

  always_comb begin
    max_o = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (delta_i[i] > max_o) begin
        max_o = delta_i[i];
      end
    end
  end

  assign hit_o = |hit_i;

endmodule

// File: rtl/fdbb_accum.sv
// Frame accumulators: changed count, largest difference and bounding box,
// plus the end-of-frame result. Depends on fdbb_pkg.
module fdbb_accum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  fdbb_pkg::pos_t                pos_i,
  input  logic [fdbb_pkg::CH_W-1:0]     max_i,
  input  logic                          hit_i,
  input  logic [fdbb_pkg::COUNT_W-1:0]  total_i,
  output fdbb_pkg::res_t                res_o
);
  import fdbb_pkg::*;

  logic [COUNT_W-1:0] cnt_q,  cnt_d;
  logic [CH_W-1:0]    ld_q,   ld_d;
  logic [COORD_W-1:0] minc_q, minc_d;
  logic [COORD_W-1:0] minr_q, minr_d;
  logic [COORD_W-1:0] maxc_q, maxc_d;
  logic [COORD_W-1:0] maxr_q, maxr_d;
  logic               upd;

  // next values include the current pixel
  always_comb begin
    upd    = pos_i.same && hit_i;
    cnt_d  = upd ? cnt_q + COUNT_W'(1) : cnt_q;
    ld_d   = (pos_i.same && (max_i > ld_q)) ? max_i : ld_q;
    minc_d = (upd && (pos_i.col < minc_q)) ? pos_i.col : minc_q;
    maxc_d = (upd && (pos_i.col > maxc_q)) ? pos_i.col : maxc_q;
    minr_d = (upd && (pos_i.row < minr_q)) ? pos_i.row : minr_q;
    maxr_d = (upd && (pos_i.row > maxr_q)) ? pos_i.row : maxr_q;
  end

  always_comb begin
    res_o            = '0;
    res_o.frame_area = total_i;
    if (!pos_i.same) begin
      res_o.changed = 1'b1;
    end else begin
      res_o.comparable = 1'b1;
      res_o.changed    = cnt_d != '0;
      res_o.diff_count = cnt_d;
      res_o.peak_delta = ld_d;
      if (cnt_d != '0) begin
        res_o.box_x      = minc_d[BOX_XY_W-1:0];
        res_o.box_y      = minr_d[BOX_XY_W-1:0];
        res_o.box_width  = BOX_WH_W'(maxc_d - minc_d + COORD_W'(1));
        res_o.box_height = BOX_WH_W'(maxr_d - minr_d + COORD_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ld_q   <= '0;
      minc_q <= '1;
      minr_q <= '1;
      maxc_q <= '0;
      maxr_q <= '0;
    end else if (en_i) begin
      if (pos_i.last) begin
        cnt_q  <= '0;
        ld_q   <= '0;
        minc_q <= '1;
        minr_q <= '1;
        maxc_q <= '0;
        maxr_q <= '0;
      end else begin
        cnt_q  <= cnt_d;
        ld_q   <= ld_d;
        minc_q <= minc_d;
        minr_q <= minr_d;
        maxc_q <= maxc_d;
        maxr_q <= maxr_d;
      end
    end
  end

endmodule

// File: rtl/frame_diff_bounding_box.sv
// Top level of the frame difference bounding box block.
// Depends on fdbb_pkg, fdbb_lane, fdbb_merge and fdbb_accum.
//
//  port group | dir | payload                               | accepted when
//  -----------+-----+---------------------------------------+----------------------
//  s_axis     | in  | before_pixel, after_pixel (64b)       | tvalid & tready
//  m_axis     | out | frame result (112b, see res_t)        | tvalid & tready
//  cfg        | in  | register index and 13-bit write data  | cfg_we_i
//
// Throughput: one pixel-pair transaction per clock while s_axis_tready is high.
// The lane register takes the frame's last pixel at its accepting edge and
//   the result register loads from it once the lane register may advance,
//   which raises m_axis_tvalid.
// s_axis_tready drops only while a frame's last pixel sits in the lane
//   register and the previous result has not been taken.
// Reset clears all control state; sizes reset to 1 and tolerance to 0.
// The frame area is registered from the size registers.
module frame_diff_bounding_box #(
  parameter int MAX_WIDTH  = fdbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side: [31:0] before_pixel, [63:32] after_pixel
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fdbb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // master side: changed, comparable, diff_count, frame_area,
  // peak_delta, box_x, box_y, box_width, box_height, 2 zero bits
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fdbb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [fdbb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fdbb_pkg::CFG_W-1:0]        cfg_data_i
);
  import fdbb_pkg::*;

  localparam logic [CFG_W+1:0] MaxW = (CFG_W+2)'(MAX_WIDTH);
  localparam logic [CFG_W+1:0] MaxH = (CFG_W+2)'(MAX_HEIGHT);

  // ---- configuration: effective (clamped) sizes ----
  logic [CFG_W-1:0]   bw_q, bh_q, aw_q, ah_q;
  logic [TOL_W-1:0]   tol_q;
  logic [COUNT_W-1:0] total_q;
  logic               same;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q  <= CFG_W'(1);
      bh_q  <= CFG_W'(1);
      aw_q  <= CFG_W'(1);
      ah_q  <= CFG_W'(1);
      tol_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BEFORE_WIDTH:  bw_q  <= clamp_size(cfg_data_i, MaxW);
        REG_BEFORE_HEIGHT: bh_q  <= clamp_size(cfg_data_i, MaxH);
        REG_AFTER_WIDTH:   aw_q  <= clamp_size(cfg_data_i, MaxW);
        REG_AFTER_HEIGHT:  ah_q  <= clamp_size(cfg_data_i, MaxH);
        REG_TOLERANCE:     tol_q <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size product, one multiplier between registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= COUNT_W'(1);
    end else begin
      total_q <= COUNT_W'(bw_q) * COUNT_W'(bh_q);
    end
  end

  assign same = (bw_q == aw_q) && (bh_q == ah_q);

  // ---- raster position, advanced on every accepted transaction ----
  logic [COORD_W-1:0] col_q, col_d, row_q, row_d;
  logic               last_col, last_row, s_acc;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign last_col = ({1'b0, col_q} + (COORD_W+1)'(1)) >= {1'b0, bw_q};
  assign last_row = ({1'b0, row_q} + (COORD_W+1)'(1)) >= {1'b0, bh_q};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last_col && last_row) begin
      col_d = '0;
      row_d = '0;
    end else if (last_col) begin
      col_d = '0;
      row_d = row_q + COORD_W'(1);
    end else begin
      col_d = col_q + COORD_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (s_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---- channel lanes ----
  logic [NUM_LANES-1:0][CH_W-1:0] lane_delta;
  logic [NUM_LANES-1:0]           lane_hit;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    fdbb_lane u_lane (
      .a_i     (s_axis_tdata[g*CH_W +: CH_W]),
      .b_i     (s_axis_tdata[PIX_W + g*CH_W +: CH_W]),
      .tol_i   (tol_q),
      .delta_o (lane_delta[g]),
      .hit_o   (lane_hit[g])
    );
  end

  // ---- lane register ----
  logic                           s1_valid_q;
  logic [NUM_LANES-1:0][CH_W-1:0] s1_delta_q;
  logic [NUM_LANES-1:0]           s1_hit_q;
  pos_t                           s1_pos_q;
  logic                           s1_adv, s1_fire;
  logic                           out_valid_q;
  res_t                           out_q;

  // a last pixel may not overwrite a result still waiting downstream
  assign s1_adv        = !(s1_pos_q.last && out_valid_q && !m_axis_tready);
  assign s1_fire       = s1_valid_q && s1_adv;
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_delta_q    <= lane_delta;
      s1_hit_q      <= lane_hit;
      s1_pos_q.col  <= col_q;
      s1_pos_q.row  <= row_q;
      s1_pos_q.last <= last_col && last_row;
      s1_pos_q.same <= same;
    end
  end

  // ---- merge and accumulate ----
  logic [CH_W-1:0] mrg_max;
  logic            mrg_hit;
  res_t            res;

  fdbb_merge u_merge (
    .delta_i (s1_delta_q),
    .hit_i   (s1_hit_q),
    .max_o   (mrg_max),
    .hit_o   (mrg_hit)
  );

  fdbb_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s1_fire),
    .pos_i   (s1_pos_q),
    .max_i   (mrg_max),
    .hit_i   (mrg_hit),
    .total_i (total_q),
    .res_o   (res)
  );

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_pos_q.last) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_pos_q.last) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// File: rtl/fdbb_checker.sv
// Port-level checker for frame_diff_bounding_box and its bind statement.
// Depends on fdbb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fdbb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [fdbb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import fdbb_pkg::*;

  res_t res;
  logic out_stall, noncomp_ok, comp_ok;

  assign res       = m_axis_tdata;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // size mismatch: flagged changed, count, box width and peak delta cleared
  assign noncomp_ok = res.changed && (res.diff_count == '0)
                   && (res.box_width == '0) && (res.peak_delta == '0);

  // comparable frames: changed flag and box agree with the count
  assign comp_ok = (res.changed == (res.diff_count != '0))
                && ((res.box_width == '0) == (res.diff_count == '0))
                && ((res.box_height == '0) == (res.diff_count == '0));

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // input back-pressure only comes from a waiting result
  `ASSERT_IMPLY(a_ready_cause, clk_i, rst_ni, !s_axis_tready, out_stall)

  `ASSERT_IMPLY(a_noncomp, clk_i, rst_ni, m_axis_tvalid && !res.comparable, noncomp_ok)

  `ASSERT_IMPLY(a_box_count, clk_i, rst_ni, m_axis_tvalid && res.comparable, comp_ok)

endmodule

bind frame_diff_bounding_box fdbb_checker u_fdbb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/testbench.sv
// Self-checking bench for frame_diff_bounding_box: streams pixel pairs, predicts
// each frame result in a scoreboard class and compares it with m_axis.
// Depends on fdbb_pkg and the RTL of the block.
module testbench;
  import fdbb_pkg::*;

  localparam int RANDOM_PAIRS   = 360;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 4;

  // Scoreboard: own copy of the registers and the frame accumulators, plus
  // the queue of frame results still owed by the block.
  class frame_result_tracker;
    logic [CFG_W-1:0]   bw_reg, bh_reg, aw_reg, ah_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [11:0]        col, row, min_col, min_row, max_col, max_row;
    logic [COUNT_W-1:0] hits;
    logic [CH_W-1:0]    peak;
    res_t               expected_frames[$];
    int unsigned        mismatches;
    int unsigned        frames_checked;

    function new();
      bw_reg  = 13'd1;
      bh_reg  = 13'd1;
      aw_reg  = 13'd1;
      ah_reg  = 13'd1;
      tol_reg = '0;
      mismatches = 0;
      frames_checked = 0;
      clear_frame();
    endfunction

    static function logic [CFG_W-1:0] eff_size(logic [CFG_W-1:0] v, int unsigned lim);
      if (v == '0) return 13'd1;
      if (v > lim) return CFG_W'(lim);
      return v;
    endfunction

    function void clear_frame();
      col     = '0;
      row     = '0;
      hits    = '0;
      peak    = '0;
      min_col = '1;
      min_row = '1;
      max_col = '0;
      max_row = '0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_BEFORE_WIDTH:  bw_reg = data;
        REG_BEFORE_HEIGHT: bh_reg = data;
        REG_AFTER_WIDTH:   aw_reg = data;
        REG_AFTER_HEIGHT:  ah_reg = data;
        REG_TOLERANCE:     tol_reg = data[TOL_W-1:0];
        default: ;
      endcase
    endfunction

    // One accepted pixel pair: accumulate, advance, and on the frame's last
    // pixel queue the expected result.
    function void note_pair(logic [PIX_W-1:0] before_px, logic [PIX_W-1:0] after_px);
      logic [CFG_W-1:0] w, h;
      logic             same, hit, last_col, last_row;
      logic [CH_W-1:0]  x, y, d;
      res_t             r;
      w    = eff_size(bw_reg, DEF_MAX_WIDTH);
      h    = eff_size(bh_reg, DEF_MAX_HEIGHT);
      same = (w == eff_size(aw_reg, DEF_MAX_WIDTH)) && (h == eff_size(ah_reg, DEF_MAX_HEIGHT));
      hit  = 1'b0;
      if (same) begin
        for (int c = 0; c < NUM_LANES; c++) begin
          x = before_px[c*CH_W +: CH_W];
          y = after_px[c*CH_W +: CH_W];
          d = (x >= y) ? x - y : y - x;
          if (d > peak) peak = d;
          if (d > tol_reg) hit = 1'b1;
        end
        if (hit) begin
          hits = hits + 1'b1;
          if (col < min_col) min_col = col;
          if (col > max_col) max_col = col;
          if (row < min_row) min_row = row;
          if (row > max_row) max_row = row;
        end
      end
      // a position beyond a shrunk size also ends its row or frame
      last_col = ({1'b0, col} + 13'd1) >= w;
      last_row = ({1'b0, row} + 13'd1) >= h;
      if (!(last_col && last_row)) begin
        if (last_col) begin
          col = '0;
          row = row + 1'b1;
        end else begin
          col = col + 1'b1;
        end
        return;
      end
      r = '0;
      r.changed    = same ? (hits != '0) : 1'b1;
      r.comparable = same;
      r.frame_area = COUNT_W'({12'd0, w} * {12'd0, h});
      if (same) begin
        r.diff_count = hits;
        r.peak_delta = peak;
        if (hits != '0) begin
          r.box_x      = min_col;
          r.box_y      = min_row;
          r.box_width  = {1'b0, max_col} - {1'b0, min_col} + 13'd1;
          r.box_height = {1'b0, max_row} - {1'b0, min_row} + 13'd1;
        end
      end
      expected_frames.push_back(r);
      clear_frame();
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_frame(res_t got);
      res_t want;
      if (expected_frames.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_frames.pop_front();
      frames_checked++;
      compare_field("changed", want.changed, got.changed);
      compare_field("comparable", want.comparable, got.comparable);
      compare_field("diff_count", want.diff_count, got.diff_count);
      compare_field("frame_area", want.frame_area, got.frame_area);
      compare_field("peak_delta", want.peak_delta, got.peak_delta);
      compare_field("box_x", want.box_x, got.box_x);
      compare_field("box_y", want.box_y, got.box_y);
      compare_field("box_width", want.box_width, got.box_width);
      compare_field("box_height", want.box_height, got.box_height);
    endfunction
  endclass

  // Clock, reset and block ports; every input known from time zero
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [31:0] before_pixel, [63:32] after_pixel
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // changed, comparable, ... box_height (res_t)
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = REG_BEFORE_WIDTH;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  frame_result_tracker tracker = new();

  int send_idle_pct = 27;
  int recv_idle_pct = 61;
  int quiet_cycles = 0;
  int pairs_accepted = 0;

  frame_diff_bounding_box dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: sees every transaction and register write at the edge it happens
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.note_pair(s_axis_tdata[PIX_W-1:0], s_axis_tdata[2*PIX_W-1:PIX_W]);
        pairs_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) tracker.check_frame(res_t'(m_axis_tdata));
      if (cfg_we_i) tracker.apply_reg(cfg_index_i, cfg_data_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Watchdog: too long without any transaction
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Offer one pixel pair, with random sender gaps, until accepted.
  // tvalid is left high so a following pair goes out back to back.
  task automatic send_pair(input logic [PIX_W-1:0] before_px, input logic [PIX_W-1:0] after_px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {after_px, before_px};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop the stream and wait for the block to go idle. A pixel that ends
  // no frame leaves nothing to wait for, so allow the pipeline depth too.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.expected_frames.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the write enable high; set_sizes lowers it after the last write
  task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] bw, input logic [CFG_W-1:0] bh,
                           input logic [CFG_W-1:0] aw, input logic [CFG_W-1:0] ah,
                           input logic [CFG_W-1:0] tol);
    settle();
    load_reg(REG_BEFORE_WIDTH, bw);
    load_reg(REG_BEFORE_HEIGHT, bh);
    load_reg(REG_AFTER_WIDTH, aw);
    load_reg(REG_AFTER_HEIGHT, ah);
    load_reg(REG_TOLERANCE, tol);
    cfg_we_i <= 1'b0;
  endtask

  // Later pixel: mostly a copy, some jitter within tolerance, some real change
  function automatic logic [PIX_W-1:0] make_after(input logic [PIX_W-1:0] before_px,
                                                  input logic [TOL_W-1:0] tol);
    logic [PIX_W-1:0] px;
    logic [CH_W-1:0]  ch;
    int               pick, lane, step;
    px   = before_px;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        ch   = px[c*CH_W +: CH_W];
        step = $urandom_range(0, tol);
        if ($urandom_range(0, 1) && (ch <= 255 - step)) begin
          ch = ch + CH_W'(step);
        end else if (ch >= step) begin
          ch = ch - CH_W'(step);
        end
        px[c*CH_W +: CH_W] = ch;
      end
    end else if (pick < 45) begin
      lane = $urandom_range(0, NUM_LANES - 1);
      px[lane*CH_W +: CH_W] = CH_W'($urandom_range(0, 255));
    end
    return px;
  endfunction

  initial begin
    logic [CFG_W-1:0] bw, bh, aw, ah, tol13;
    logic [PIX_W-1:0] px;
    int               w, h, pick, n, pairs_sent;

    pairs_sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes 1x1, tolerance 0: one result per pixel
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    send_pair(32'h1234_5678, 32'h1234_5679);

    // 3x2, tolerance 16 with junk in the upper data bits: 16 is unchanged, 17 is not
    set_sizes(13'd3, 13'd2, 13'd3, 13'd2, 13'h1F10);
    send_pair(32'h1010_1010, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h1100_0000);
    send_pair(32'h0000_0080, 32'h0000_0080);
    send_pair(32'h0000_00FF, 32'h0000_00EF);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h00AB_0000, 32'h0000_0000);

    // Sizes differ: pixels ignored, frame still runs to the before size
    set_sizes(13'd2, 13'd2, 13'd2, 13'd3, 13'd0);
    repeat (4) send_pair($urandom, $urandom);

    // Zero sizes act as one, so these compare equal; tolerance at its top
    set_sizes(13'd0, 13'd1, 13'd1, 13'd0, 13'h00FF);
    send_pair(32'hFFFF_FFFF, 32'h0000_0000);

    // Resize part-way through a frame: column 1 now ends its row
    set_sizes(13'd3, 13'd3, 13'd3, 13'd3, 13'd0);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0000_0001, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h0000_0100);
    set_sizes(13'd1, 13'd3, 13'd1, 13'd3, 13'd0);
    send_pair(32'h0000_0055, 32'h0000_0056);
    send_pair(32'h0000_0000, 32'h0000_0000);

    // Out-of-range width clamps to the limit and compares equal with it;
    // a narrower width then cuts the first row short at column 3
    set_sizes(13'h1FFF, 13'd2, 13'd4096, 13'd2, 13'd0);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h0000_0300);
    send_pair(32'h0000_0000, 32'h0000_0000);
    set_sizes(13'd3, 13'd2, 13'd3, 13'd2, 13'd0);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0000_FF00, 32'h0000_0000);

    // Same for the height: clamped rows first, then row 3 ends the frame
    set_sizes(13'd1, 13'h1FFF, 13'd0, 13'd4096, 13'h1E07);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h1000_0000);
    send_pair(32'h0000_0000, 32'h0000_0007);
    set_sizes(13'd1, 13'd3, 13'd1, 13'd3, 13'h1E07);
    send_pair(32'h0000_0000, 32'h0000_0008);

    // Random part: small frames, up to four back to back per setting
    while (pairs_sent < RANDOM_PAIRS) begin
      if (pairs_sent >= 2 * RANDOM_PAIRS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (pairs_sent >= RANDOM_PAIRS / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 27;
      end
      w  = $urandom_range(1, 6);
      h  = $urandom_range(1, 5);
      bw = CFG_W'(w);
      bh = CFG_W'(h);
      aw = bw;
      ah = bh;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        if ($urandom_range(0, 1)) begin
          aw = (w > 1 && $urandom_range(0, 1)) ? bw - 1'b1 : bw + 1'b1;
        end else begin
          ah = (h > 1 && $urandom_range(0, 1)) ? bh - 1'b1 : bh + 1'b1;
        end
      end else if (pick < 18) begin
        aw = CFG_W'($urandom_range(DEF_MAX_WIDTH + 1, 8191));   // clamps, so never equal
      end else if (pick < 26) begin
        if (w == 1) bw = '0;
        if (h == 1) ah = '0;
      end
      pick = $urandom_range(0, 99);
      tol13[CFG_W-1:TOL_W] = (CFG_W-TOL_W)'($urandom_range(0, 31));
      if (pick < 45) begin
        tol13[TOL_W-1:0] = TOL_W'($urandom_range(0, 8));
      end else if (pick < 75) begin
        tol13[TOL_W-1:0] = TOL_W'($urandom_range(9, 60));
      end else if (pick < 90) begin
        tol13[TOL_W-1:0] = TOL_W'($urandom_range(61, 254));
      end else if (pick < 95) begin
        tol13[TOL_W-1:0] = 8'd0;
      end else begin
        tol13[TOL_W-1:0] = 8'd255;
      end
      set_sizes(bw, bh, aw, ah, tol13);
      n = int'(frame_result_tracker::eff_size(bw, DEF_MAX_WIDTH))
        * int'(frame_result_tracker::eff_size(bh, DEF_MAX_HEIGHT))
        * $urandom_range(1, 4);
      repeat (n) begin
        px = $urandom;
        send_pair(px, make_after(px, tol13[TOL_W-1:0]));
        pairs_sent++;
      end
    end

    settle();
    repeat (8) @(posedge clk_i);

    $display("Checked %0d frame results over %0d pixel pair transactions.",
             tracker.frames_checked, pairs_accepted);
    $display("Frames from 1x1 to 6x5, unequal, zero and clamped sizes, mid-frame resizes.");
    if (tracker.mismatches == 0 && tracker.expected_frames.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/fdbb_pkg.sv
rtl/fdbb_lane.sv
rtl/fdbb_merge.sv
rtl/fdbb_accum.sv
rtl/frame_diff_bounding_box.sv
rtl/fdbb_checker.sv
tb/testbench.sv
